// ===== src/pdff_speed_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// PDFF speed controller assertion macros
// Clocked assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PDFF_SPEED_CONTROLLER_CORE_DEFINES_SVH
`define PDFF_SPEED_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Assertion that is switched off while reset is high
`define PDFF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that also holds during reset
`define PDFF_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDFF_ASSERT(name, clk, rst, prop, msg)
`define PDFF_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== src/pdff_pkg.sv =====
// ----------------------------------------------------------------------------
// PDFF speed controller package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package pdff_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_FEEDFORWARD_GAIN = 3'd0;
   localparam logic [2:0] REG_DAMPING_GAIN     = 3'd1;
   localparam logic [2:0] REG_PROP_GAIN        = 3'd2;
   localparam logic [2:0] REG_INTEG_GAIN       = 3'd3;
   localparam logic [2:0] REG_OUTPUT_SCALE     = 3'd4;

   // Reset values
   localparam logic [15:0] FEEDFORWARD_GAIN_RST = 16'd4096;
   localparam logic [15:0] DAMPING_GAIN_RST     = 16'd4096;

   // Saturation flag codes
   localparam logic [1:0] SAT_FREE      = 2'd0;
   localparam logic [1:0] SAT_NEG_LIMIT = 2'd1;
   localparam logic [1:0] SAT_POS_LIMIT = 2'd2;
   localparam logic [1:0] SAT_HOLD      = 2'd3;

   // Fixed-point shifts and output limits
   localparam int unsigned Q_WEIGHT  = 12;
   localparam int unsigned Q_INTEG   = 10;
   localparam int unsigned Q_SCALE   = 38;
   localparam logic signed [25:0] OUT_POS_LIMIT = 26'sd32767;
   localparam logic signed [25:0] OUT_NEG_LIMIT = -26'sd32767;

   typedef struct packed {
      logic [15:0] feedforward_gain;
      logic [15:0] damping_gain;
      logic [15:0] prop_gain;
      logic [15:0] integ_gain;
      logic [31:0] output_scale;
   } gains_type;

   // Operand pair presented to the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE = 3'd0,
      MUL_REF  = 3'd1,
      MUL_FB   = 3'd2,
      MUL_KP   = 3'd3,
      MUL_KI   = 3'd4,
      MUL_LO   = 3'd5,
      MUL_HI   = 3'd6
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      logic        load_refw;
      logic        load_total;
      logic        upd_sum;
      logic        add_sum;
      logic        load_lo;
      logic        load_out;
   } cmd_type;

endpackage

// ===== src/pdff_csr.sv =====
// ----------------------------------------------------------------------------
// PDFF configuration registers
// Holds the gains and the output scale written through the register port.
// ----------------------------------------------------------------------------
module pdff_csr
   import pdff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output gains_type   gains
);

   gains_type gains_ff;
   gains_type gains_in;

   assign csr_ready = 1'b1;
   assign gains     = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FEEDFORWARD_GAIN: gains_in.feedforward_gain = csr_data[15:0];
            REG_DAMPING_GAIN:     gains_in.damping_gain     = csr_data[15:0];
            REG_PROP_GAIN:        gains_in.prop_gain        = csr_data[15:0];
            REG_INTEG_GAIN:       gains_in.integ_gain       = csr_data[15:0];
            REG_OUTPUT_SCALE:     gains_in.output_scale     = csr_data;
            default:              gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.feedforward_gain <= FEEDFORWARD_GAIN_RST;
         gains_ff.damping_gain     <= DAMPING_GAIN_RST;
         gains_ff.prop_gain        <= '0;
         gains_ff.integ_gain       <= '0;
         gains_ff.output_scale     <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

// ===== src/pdff_ctrl.sv =====
// ----------------------------------------------------------------------------
// PDFF controller
// Sequences one item through the shared multiplier and drives the handshakes.
// ----------------------------------------------------------------------------
`include "pdff_speed_controller_core_defines.svh"

module pdff_ctrl
   import pdff_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_MREF = 10'b0000000010,
      ST_MFB  = 10'b0000000100,
      ST_MKP  = 10'b0000001000,
      ST_MKI  = 10'b0000010000,
      ST_ACC  = 10'b0000100000,
      ST_ADD  = 10'b0001000000,
      ST_MLO  = 10'b0010000000,
      ST_MHI  = 10'b0100000000,
      ST_FIN  = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_blocked;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign out_blocked = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MREF;
            end
         end
         ST_MREF: begin
            cmd.mul_sel = MUL_REF;
            state_in    = ST_MFB;
         end
         ST_MFB: begin
            cmd.mul_sel   = MUL_FB;
            cmd.load_refw = 1'b1;
            state_in      = ST_MKP;
         end
         ST_MKP: begin
            cmd.mul_sel = MUL_KP;
            state_in    = ST_MKI;
         end
         ST_MKI: begin
            cmd.mul_sel    = MUL_KI;
            cmd.load_total = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            cmd.upd_sum = 1'b1;
            state_in    = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_sum = 1'b1;
            state_in    = ST_MLO;
         end
         ST_MLO: begin
            cmd.mul_sel = MUL_LO;
            state_in    = ST_MHI;
         end
         ST_MHI: begin
            cmd.mul_sel = MUL_HI;
            cmd.load_lo = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            // hold the finished product until the output register frees up;
            // keep the upper multiply selected so the product register holds
            cmd.mul_sel = MUL_HI;
            if (!out_blocked) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PDFF_ASSERT(a_accept_starts, clock, reset,
      req_valid && !req_stall |=> state_ff == ST_MREF,
      "accepted item did not start the multiply sequence")
   `PDFF_ASSERT(a_rsp_from_fin, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN),
      "result appeared without finishing an item")
   `PDFF_ASSERT(a_fin_holds, clock, reset,
      state_ff == ST_FIN && out_blocked |=> state_ff == ST_FIN && rsp_valid_ff,
      "finished item dropped while the output was stalled")

endmodule

// ===== src/pdff_dp.sv =====
// ----------------------------------------------------------------------------
// PDFF datapath
// Shared 33x33 multiplier, integral accumulator, scaling and output clamp.
// ----------------------------------------------------------------------------
`include "pdff_speed_controller_core_defines.svh"

module pdff_dp
   import pdff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  gains_type   gains,
   input  logic [31:0] req_reference,
   input  logic [31:0] req_feedback_prop,
   input  logic [31:0] req_feedback_integ,
   input  logic [1:0]  req_sat_state,
   output logic [15:0] rsp_drive_out
);

   logic [31:0] ref_ff;
   logic [31:0] fbp_ff;
   logic [31:0] fbi_ff;
   logic [1:0]  sat_ff;
   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [31:0] refw_ff;
   logic [63:0] total_ff;
   logic [63:0] total_in;
   logic [63:0] sum_ff;
   logic [63:0] sum_in;
   logic [31:0] lo_ff;
   logic [15:0] drive_ff;
   logic [15:0] drive_in;

   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_full;
   logic [31:0] diff;
   logic [31:0] err;
   logic        err_neg;
   logic        err_pos;
   logic        sum_add;
   logic [31:0] hi32;
   logic signed [25:0] scaled;

   assign diff    = refw_ff - prod_ff[Q_WEIGHT +: 32];
   assign err     = ref_ff - fbi_ff;
   assign err_neg = err[31];
   assign err_pos = !err[31] && (err != '0);
   assign sum_add = (sat_ff == SAT_FREE) ||
                    ((sat_ff == SAT_NEG_LIMIT) && err_pos) ||
                    ((sat_ff == SAT_POS_LIMIT) && err_neg);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_REF: begin
            mul_a = {ref_ff[31], ref_ff};
            mul_b = {17'b0, gains.feedforward_gain};
         end
         MUL_FB: begin
            mul_a = {fbp_ff[31], fbp_ff};
            mul_b = {17'b0, gains.damping_gain};
         end
         MUL_KP: begin
            mul_a = {diff[31], diff};
            mul_b = {17'b0, gains.prop_gain};
         end
         MUL_KI: begin
            mul_a = {err[31], err};
            mul_b = {17'b0, gains.integ_gain};
         end
         MUL_LO: begin
            mul_a = {1'b0, total_ff[31:0]};
            mul_b = {1'b0, gains.output_scale};
         end
         MUL_HI: begin
            mul_a = {1'b0, total_ff[63:32]};
            mul_b = {1'b0, gains.output_scale};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[63:0];

   always_comb begin
      sum_in = sum_ff;
      if (cmd.upd_sum) begin
         if (gains.integ_gain == '0) begin
            sum_in = '0;
         end else if (sum_add) begin
            sum_in = sum_ff + prod_ff;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.load_total) begin
         total_in = prod_ff;
      end else if (cmd.add_sum) begin
         total_in = total_ff + 64'($signed(sum_ff) >>> Q_INTEG);
      end
   end

   // upper word of the 64-bit wrapped product; keep bits 63..38 as signed
   assign hi32   = lo_ff + prod_ff[31:0];
   assign scaled = $signed(hi32[31:Q_SCALE - 32]);

   always_comb begin
      if (scaled > OUT_POS_LIMIT) begin
         drive_in = OUT_POS_LIMIT[15:0];
      end else if (scaled < OUT_NEG_LIMIT) begin
         drive_in = OUT_NEG_LIMIT[15:0];
      end else begin
         drive_in = scaled[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ref_ff <= req_reference;
         fbp_ff <= req_feedback_prop;
         fbi_ff <= req_feedback_integ;
         sat_ff <= req_sat_state;
      end
      if (cmd.load_refw) begin
         refw_ff <= prod_ff[Q_WEIGHT +: 32];
      end
      if (cmd.load_lo) begin
         lo_ff <= prod_ff[63:32];
      end
      if (cmd.load_out) begin
         drive_ff <= drive_in;
      end
      prod_ff  <= prod_in;
      total_ff <= total_in;
   end

   assign rsp_drive_out = drive_ff;

   `PDFF_ASSERT(a_zero_ki_clears, clock, reset,
      cmd.upd_sum && gains.integ_gain == '0 |=> sum_ff == '0,
      "integral sum not cleared with zero integral gain")
   `PDFF_ASSERT(a_hold_keeps_sum, clock, reset,
      cmd.upd_sum && sat_ff == SAT_HOLD && gains.integ_gain != '0 |=> $stable(sum_ff),
      "integral sum changed while held")
   `PDFF_ASSERT(a_out_in_range, clock, reset,
      cmd.load_out |-> $signed(drive_in) <= 16'sd32767 && $signed(drive_in) >= -16'sd32767,
      "clamped output out of range")

endmodule

// ===== src/pdff_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// PDFF speed controller core
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Each accepted item runs through the states MREF, MFB, MKP, MKI, ACC, ADD,
// MLO, MHI and FIN before the next is accepted: six passes through one shared
// 33x33 multiplier (feedforward weight, feedback weight, proportional gain,
// integral gain and the two halves of the output scale), the accumulator
// update, the integral add and the clamp. FIN loads the result into an output
// register, waiting while a stalled result still sits there; the next item is
// taken while the result waits. Gains are written at any time through the csr
// port and must only change while no item is in progress.
module pdff_speed_controller_core
   import pdff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_reference,
   input  logic [31:0] req_feedback_prop,
   input  logic [31:0] req_feedback_integ,
   input  logic [1:0]  req_sat_state,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_drive_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   gains_type gains;
   cmd_type   cmd;

   pdff_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .gains     (gains)
   );

   pdff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pdff_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .gains              (gains),
      .req_reference      (req_reference),
      .req_feedback_prop  (req_feedback_prop),
      .req_feedback_integ (req_feedback_integ),
      .req_sat_state      (req_sat_state),
      .rsp_drive_out      (rsp_drive_out)
   );

endmodule

// ===== tb/sv/pdff_speed_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// PDFF speed controller core testbench
// Sends controller samples through the core under several gain settings and
// idle patterns. A predictor tracks the integral sum and gains and checks each
// clamped drive value in order.
// ----------------------------------------------------------------------------
module pdff_speed_controller_core_test
   import pdff_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SEGMENTS       = 8;
   localparam int SEGMENT_ITEMS  = 129;
   localparam int LONG_HOLD      = 80;
   localparam int SETTLE_CYCLES  = 12;
   localparam int REPORT_LIMIT   = 10;

   // Predicts the clamped drive value for each accepted sample
   class pdff_drive_predictor;
      logic [15:0] kf, kd, kp, ki;
      logic [31:0] scale;
      logic [63:0] integ_sum;
      logic [15:0] expected_drive[$];
      int          mismatches;
      int          compared;

      function new();
         kf = FEEDFORWARD_GAIN_RST;
         kd = DAMPING_GAIN_RST;
         kp = '0;
         ki = '0;
         scale = '0;
         integ_sum = '0;
         mismatches = 0;
         compared = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            REG_FEEDFORWARD_GAIN: kf = data[15:0];
            REG_DAMPING_GAIN:     kd = data[15:0];
            REG_PROP_GAIN:        kp = data[15:0];
            REG_INTEG_GAIN:       ki = data[15:0];
            REG_OUTPUT_SCALE:     scale = data;
            default: ;
         endcase
      endfunction

      // Q12 weighting: arithmetic shift by 12, keep the low 32 bits
      function logic [31:0] q12_weight(logic [31:0] value, logic [15:0] gain);
         logic signed [63:0] prod;
         prod = $signed({{32{value[31]}}, value}) * $signed({48'd0, gain});
         return prod[43:12];
      endfunction

      function void note_item(logic [31:0] reference, logic [31:0] fbp,
                              logic [31:0] fbi, logic [1:0] sat);
         logic [31:0]        diff;
         logic [31:0]        err;
         logic [63:0]        total;
         logic [63:0]        sum_q;
         logic signed [31:0] clipped;
         logic               take;
         diff = q12_weight(reference, kf) - q12_weight(fbp, kd);
         total = {48'd0, kp} * {{32{diff[31]}}, diff};
         err = reference - fbi;
         if (ki == 16'd0) begin
            integ_sum = '0;
         end else begin
            take = (sat == SAT_FREE)
                || (sat == SAT_NEG_LIMIT && !err[31] && err != 32'd0)
                || (sat == SAT_POS_LIMIT && err[31]);
            if (take) integ_sum = integ_sum + {48'd0, ki} * {{32{err[31]}}, err};
         end
         sum_q = $signed(integ_sum) >>> Q_INTEG;
         total = total + sum_q;
         total = total * {32'd0, scale};
         total = $signed(total) >>> Q_SCALE;
         clipped = total[31:0];
         if (clipped > OUT_POS_LIMIT) clipped = 32'(OUT_POS_LIMIT);
         else if (clipped < OUT_NEG_LIMIT) clipped = 32'(OUT_NEG_LIMIT);
         expected_drive.push_back(clipped[15:0]);
      endfunction

      function void check_drive(logic [15:0] got);
         logic [15:0] want;
         if (expected_drive.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: drive_out %h arrived with nothing outstanding", $realtime, got);
         end else begin
            want = expected_drive.pop_front();
            compared++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: drive_out mismatch: expected %0d (%h), got %0d (%h)",
                           $realtime, $signed(want), want, $signed(got), got);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_reference = '0;
   logic [31:0] req_feedback_prop = '0;
   logic [31:0] req_feedback_integ = '0;
   logic [1:0]  req_sat_state = SAT_FREE;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_drive_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = REG_FEEDFORWARD_GAIN;
   logic [31:0] csr_data = '0;

   pdff_drive_predictor model = new();

   int cycle_count = 0;
   int items_sent = 0;
   int settings_used = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 57;
   int long_holds_asked = 0;
   int long_holds_served = 0;
   int hold_left = 0;

   pdff_speed_controller_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reference      (req_reference),
      .req_feedback_prop  (req_feedback_prop),
      .req_feedback_integ (req_feedback_integ),
      .req_sat_state      (req_sat_state),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_out      (rsp_drive_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold whenever one is asked for
   always @(negedge clock) begin
      if (long_holds_served < long_holds_asked) begin
         hold_left = LONG_HOLD;
         long_holds_served++;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) model.check_drive(rsp_drive_out);
   end

   // All driving tasks start and end just after a falling edge
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      do @(posedge clock); while (!csr_ready);
      model.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_item(input logic [31:0] reference, input logic [31:0] fbp,
                            input logic [31:0] fbi, input logic [1:0] sat);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_reference = reference;
      req_feedback_prop = fbp;
      req_feedback_integ = fbi;
      req_sat_state = sat;
      do @(posedge clock); while (req_stall);
      model.note_item(reference, fbp, fbi, sat);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected drive value has come back
   task automatic wait_idle();
      req_valid = 1'b0;
      while (model.expected_drive.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_gains(input logic [15:0] ff, input logic [15:0] damp,
                             input logic [15:0] prop, input logic [15:0] integ,
                             input logic [31:0] scale);
      write_reg(REG_FEEDFORWARD_GAIN, {16'($urandom), ff});
      write_reg(REG_DAMPING_GAIN, {16'($urandom), damp});
      write_reg(REG_PROP_GAIN, {16'($urandom), prop});
      write_reg(REG_INTEG_GAIN, {16'($urandom), integ});
      write_reg(REG_OUTPUT_SCALE, scale);
      // unused index, must be ignored
      write_reg(3'($urandom_range(7, 5)), $urandom);
      settings_used++;
   endtask

   // Values of every magnitude, either sign
   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(3, 0) != 0) w = w >> $urandom_range(31, 0);
      if ($urandom_range(1, 0) == 1) w = ~w;
      return w;
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(3, 0))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535, 0) >> $urandom_range(15, 0));
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(7, 0))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom >> $urandom_range(31, 0);
      endcase
   endfunction

   task automatic run_segment(input int seg);
      logic [31:0] reference;
      logic [31:0] fbp;
      logic [31:0] fbi;
      wait_idle();
      if (seg < 3) begin
         send_idle_pct = 37;
         recv_idle_pct = 57;
      end else if (seg < 6) begin
         send_idle_pct = 57;
         recv_idle_pct = 37;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      case (seg)
         0: load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
         1: load_gains(16'd0, 16'd0, 16'd0, 16'd1, 32'hFFFF_FFFF);
         default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                             pick_scale());
      endcase
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
         // stall the output long enough to back the core up
         if (i == SEGMENT_ITEMS / 2 && (seg == 2 || seg == 6)) long_holds_asked++;
         reference = rand_word();
         fbp = ($urandom_range(1, 0) == 1) ? rand_word() : reference - rand_word();
         case ($urandom_range(3, 0))
            0: fbi = reference;
            1: fbi = rand_word();
            default: fbi = reference - rand_word();
         endcase
         send_item(reference, fbp, fbi, 2'($urandom_range(3, 0)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset gains: output must be zero
      send_item(32'd6400, 32'd0, 32'd0, SAT_FREE);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, SAT_FREE);
      wait_idle();

      // Unit gains, scale 2^31: drive is the total shifted right by 7
      load_gains(16'd4096, 16'd4096, 16'd1, 16'd1024, 32'h8000_0000);
      send_item(32'd6400, 32'd0, 32'd0, SAT_FREE);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, SAT_FREE);
      send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, SAT_FREE);
      send_item(32'd0, 32'd0, 32'd0, SAT_FREE);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SAT_FREE);
      // anti-windup: accumulate only in the direction away from the limit
      send_item(32'd1000, 32'd0, 32'd0, SAT_NEG_LIMIT);
      send_item(32'd0, 32'd0, 32'd1000, SAT_NEG_LIMIT);
      send_item(32'd5, 32'd0, 32'd5, SAT_NEG_LIMIT);
      send_item(32'd0, 32'd0, 32'd1000, SAT_POS_LIMIT);
      send_item(32'd1000, 32'd0, 32'd0, SAT_POS_LIMIT);
      send_item(32'd5, 32'd0, 32'd5, SAT_POS_LIMIT);
      send_item(32'd1000, 32'd0, 32'd0, SAT_HOLD);
      // clamp at both limits
      send_item(32'h0100_0000, 32'd0, 32'h0100_0000, SAT_HOLD);
      send_item(32'hFF00_0000, 32'd0, 32'hFF00_0000, SAT_HOLD);
      wait_idle();

      // Zero integral gain clears the sum
      write_reg(REG_INTEG_GAIN, 32'd0);
      send_item(32'd500, 32'd0, 32'd0, SAT_FREE);
      wait_idle();
      write_reg(REG_INTEG_GAIN, 32'd1024);
      send_item(32'd500, 32'd0, 32'd0, SAT_FREE);
      send_item(32'hFFFF_FF00, 32'd0, 32'd0, SAT_FREE);

      for (int seg = 0; seg < SEGMENTS; seg++) run_segment(seg);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d gain settings; compared %0d drive values.",
               items_sent, settings_used, model.compared);
      $display("Idle mixes on both sides, %0d long output holds, anti-windup flags covered.",
               long_holds_served);
      if (model.expected_drive.size() != 0)
         $display("%0d expected drive values never arrived", model.expected_drive.size());
      if (model.mismatches == 0 && model.expected_drive.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== pdff_speed_controller_core.f =====
+incdir+src
src/pdff_pkg.sv
src/pdff_csr.sv
src/pdff_ctrl.sv
src/pdff_dp.sv
src/pdff_speed_controller_core.sv
tb/sv/pdff_speed_controller_core_test.sv
